FILE: hw/rtl/sorted_keyframe_table_unit_defines.svh
// Assertion macros for the sorted keyframe table unit.
// Included by the top level only; depends on nothing else.
`ifndef SORTED_KEYFRAME_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEYFRAME_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, silenced while reset is high.
`define SKT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, silenced while reset is high.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/skt_pkg.sv
// Shared types, codes and the microcode program of the sorted keyframe table.
// Used by sorted_keyframe_table_unit; no dependencies.
package skt_pkg;

   localparam int MAX_FRAMES_DEFAULT = 16;
   localparam int TIME_W = 32;
   localparam int ID_W   = 16;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                     req_type;
      logic signed [TIME_W-1:0] key_time;
      logic [ID_W-1:0]          frame_id;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [1:0]      frame_count;
      logic [ID_W-1:0] upper_id;
      logic [ID_W-1:0] lower_id;
   } rsp_beat_type;

   typedef struct packed {
      logic signed [TIME_W-1:0] key_time;
      logic [ID_W-1:0]          frame_id;
   } entry_type;

   typedef enum logic [4:0] {
      STEP_IDLE        = 5'd0,
      STEP_DISPATCH    = 5'd1,
      STEP_INS_CHECK   = 5'd2,
      STEP_INS_INIT    = 5'd3,
      STEP_INS_READ    = 5'd4,
      STEP_INS_TEST    = 5'd5,
      STEP_INS_SHIFT   = 5'd6,
      STEP_INS_PLACE   = 5'd7,
      STEP_INS_FULL    = 5'd8,
      STEP_LK_FIRST    = 5'd9,
      STEP_LK_FIRST_T  = 5'd10,
      STEP_LK_LAST     = 5'd11,
      STEP_LK_LAST_T   = 5'd12,
      STEP_LK_READ     = 5'd13,
      STEP_LK_TEST     = 5'd14,
      STEP_LK_STEP     = 5'd15,
      STEP_LK_BRACKET  = 5'd16,
      STEP_LK_SINGLE   = 5'd17,
      STEP_LK_EMPTY    = 5'd18
   } step_type;

   typedef enum logic [1:0] {
      ADDR_ZERO, ADDR_LAST, ADDR_IDX, ADDR_IDX_M1
   } addr_sel_type;

   typedef enum logic [1:0] {
      WR_NONE, WR_SHIFT, WR_NEW
   } wr_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD, IDX_LOAD_COUNT, IDX_LOAD_ONE, IDX_INC, IDX_DEC
   } idx_op_type;

   typedef enum logic [2:0] {
      RSP_NONE, RSP_OK, RSP_FULL, RSP_EMPTY, RSP_SINGLE, RSP_BRACKET
   } rsp_op_type;

   typedef enum logic [3:0] {
      COND_NEVER, COND_ALWAYS, COND_NO_REQ, COND_IS_LOOKUP, COND_FULL,
      COND_EMPTY, COND_IDX_ZERO, COND_RD_LE_T, COND_RD_GE_T, COND_T_AT_FIRST
   } cond_type;

   typedef struct packed {
      logic         rd_en;
      addr_sel_type addr_sel;
      wr_sel_type   wr_sel;
      idx_op_type   idx_op;
      logic         cnt_inc;
      logic         save_prev;
      rsp_op_type   rsp_op;
      cond_type     cond;
      step_type     target;
   } ucode_type;

   function automatic ucode_type uword(logic rd, addr_sel_type addr, wr_sel_type wr,
                                       idx_op_type iop, logic cinc, logic sprev,
                                       rsp_op_type rop, cond_type c, step_type tgt);
      ucode_type w;
      w.rd_en     = rd;
      w.addr_sel  = addr;
      w.wr_sel    = wr;
      w.idx_op    = iop;
      w.cnt_inc   = cinc;
      w.save_prev = sprev;
      w.rsp_op    = rop;
      w.cond      = c;
      w.target    = tgt;
      return w;
   endfunction

   // Control store: jump to target when the condition holds, else fall through.
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      case (step)
         STEP_IDLE:       w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_NONE, COND_NO_REQ, STEP_IDLE);
         STEP_DISPATCH:   w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_NONE, COND_IS_LOOKUP, STEP_LK_FIRST);
         STEP_INS_CHECK:  w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_NONE, COND_FULL, STEP_INS_FULL);
         STEP_INS_INIT:   w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_LOAD_COUNT, 1'b0, 1'b0,
                                    RSP_NONE, COND_NEVER, STEP_IDLE);
         STEP_INS_READ:   w = uword(1'b1, ADDR_IDX_M1, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_NONE, COND_IDX_ZERO, STEP_INS_PLACE);
         STEP_INS_TEST:   w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_NONE, COND_RD_LE_T, STEP_INS_PLACE);
         STEP_INS_SHIFT:  w = uword(1'b0, ADDR_ZERO, WR_SHIFT, IDX_DEC, 1'b0, 1'b0,
                                    RSP_NONE, COND_ALWAYS, STEP_INS_READ);
         STEP_INS_PLACE:  w = uword(1'b0, ADDR_ZERO, WR_NEW, IDX_HOLD, 1'b1, 1'b0,
                                    RSP_OK, COND_ALWAYS, STEP_IDLE);
         STEP_INS_FULL:   w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_FULL, COND_ALWAYS, STEP_IDLE);
         STEP_LK_FIRST:   w = uword(1'b1, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_NONE, COND_EMPTY, STEP_LK_EMPTY);
         STEP_LK_FIRST_T: w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b1,
                                    RSP_NONE, COND_T_AT_FIRST, STEP_LK_SINGLE);
         STEP_LK_LAST:    w = uword(1'b1, ADDR_LAST, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_NONE, COND_NEVER, STEP_IDLE);
         STEP_LK_LAST_T:  w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_LOAD_ONE, 1'b0, 1'b0,
                                    RSP_NONE, COND_RD_LE_T, STEP_LK_SINGLE);
         STEP_LK_READ:    w = uword(1'b1, ADDR_IDX, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_NONE, COND_NEVER, STEP_IDLE);
         STEP_LK_TEST:    w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_NONE, COND_RD_GE_T, STEP_LK_BRACKET);
         STEP_LK_STEP:    w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_INC, 1'b0, 1'b1,
                                    RSP_NONE, COND_ALWAYS, STEP_LK_READ);
         STEP_LK_BRACKET: w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_BRACKET, COND_ALWAYS, STEP_IDLE);
         STEP_LK_SINGLE:  w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_SINGLE, COND_ALWAYS, STEP_IDLE);
         STEP_LK_EMPTY:   w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_EMPTY, COND_ALWAYS, STEP_IDLE);
         default:         w = uword(1'b0, ADDR_ZERO, WR_NONE, IDX_HOLD, 1'b0, 1'b0,
                                    RSP_NONE, COND_ALWAYS, STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

FILE: hw/rtl/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skt_ram #(
   parameter  int WIDTH = 48,
   parameter  int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sorted_keyframe_table_unit.sv
// Sorted keyframe table: (time, id) entries in one RAM, run by a microcoded sequencer.
// An insert shifts up every entry later than the new key and then places it; it is dropped
// when the table is full. A lookup reports empty, a single frame at or before the first key
// (or for a time of zero or less) or at or beyond the last, else the bracketing pair found
// by stepping past entries from the start. One item at a time; result stalls hold it up.
// Reset (synchronous, active high) empties the table at once; needs skt_pkg and skt_ram.
`include "sorted_keyframe_table_unit_defines.svh"

module sorted_keyframe_table_unit #(
   parameter int MAX_FRAMES = skt_pkg::MAX_FRAMES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  skt_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output skt_pkg::rsp_beat_type rsp_beat
);

   localparam int AW = $clog2(MAX_FRAMES);
   localparam int CW = $clog2(MAX_FRAMES + 1);

   // Sequencer state
   skt_pkg::step_type  pc_ff, pc_in;
   skt_pkg::ucode_type uw;
   logic               cond_hit;
   logic               hold;

   // Datapath registers
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             count_ff, count_in;
   skt_pkg::req_beat_type     req_ff;
   logic [skt_pkg::ID_W-1:0]  prev_ff;
   skt_pkg::rsp_beat_type     rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // RAM port
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   skt_pkg::entry_type   ram_wr_data;
   skt_pkg::entry_type   rd_entry;

   logic signed [skt_pkg::TIME_W-1:0] rd_time;
   logic signed [skt_pkg::TIME_W-1:0] req_time;

   assign uw       = skt_pkg::ucode_rom(pc_ff);
   assign rd_time  = rd_entry.key_time;
   assign req_time = req_ff.key_time;

   // Take a new beat only from the idle step; the result register decouples the far side.
   assign req_stall = (pc_ff != skt_pkg::STEP_IDLE);

   // Hold a result-producing step while the previous result is still waiting.
   assign hold = (uw.rsp_op != skt_pkg::RSP_NONE) && rsp_valid_ff && rsp_stall;

   // Branch conditions
   always_comb begin
      case (uw.cond)
         skt_pkg::COND_NEVER:      cond_hit = 1'b0;
         skt_pkg::COND_ALWAYS:     cond_hit = 1'b1;
         skt_pkg::COND_NO_REQ:     cond_hit = !req_valid;
         skt_pkg::COND_IS_LOOKUP:  cond_hit = (req_ff.req_type == skt_pkg::REQ_LOOKUP);
         skt_pkg::COND_FULL:       cond_hit = (count_ff == CW'(MAX_FRAMES));
         skt_pkg::COND_EMPTY:      cond_hit = (count_ff == '0);
         skt_pkg::COND_IDX_ZERO:   cond_hit = (idx_ff == '0);
         skt_pkg::COND_RD_LE_T:    cond_hit = (rd_time <= req_time);
         skt_pkg::COND_RD_GE_T:    cond_hit = (rd_time >= req_time);
         skt_pkg::COND_T_AT_FIRST: cond_hit = (req_time <= 0) || (rd_time >= req_time);
         default:                  cond_hit = 1'b0;
      endcase
   end

   // Next step: jump on a hit, else fall through; freeze while held.
   always_comb begin
      if (hold) begin
         pc_in = pc_ff;
      end else if (cond_hit) begin
         pc_in = uw.target;
      end else begin
         pc_in = skt_pkg::step_type'(pc_ff + 5'd1);
      end
   end

   // Read address select
   always_comb begin
      case (uw.addr_sel)
         skt_pkg::ADDR_ZERO:   ram_rd_addr = '0;
         skt_pkg::ADDR_LAST:   ram_rd_addr = AW'(count_ff - CW'(1));
         skt_pkg::ADDR_IDX:    ram_rd_addr = idx_ff[AW-1:0];
         skt_pkg::ADDR_IDX_M1: ram_rd_addr = AW'(idx_ff - CW'(1));
         default:              ram_rd_addr = '0;
      endcase
   end

   assign ram_rd_en = uw.rd_en && !hold;
   assign ram_wr_en = (uw.wr_sel != skt_pkg::WR_NONE) && !hold;

   // Shift moves the entry just read up one slot; a place writes the new keyframe.
   always_comb begin
      if (uw.wr_sel == skt_pkg::WR_SHIFT) begin
         ram_wr_data = rd_entry;
      end else begin
         ram_wr_data.key_time = req_ff.key_time;
         ram_wr_data.frame_id = req_ff.frame_id;
      end
   end

   // Walk index
   always_comb begin
      case (uw.idx_op)
         skt_pkg::IDX_HOLD:       idx_in = idx_ff;
         skt_pkg::IDX_LOAD_COUNT: idx_in = count_ff;
         skt_pkg::IDX_LOAD_ONE:   idx_in = CW'(1);
         skt_pkg::IDX_INC:        idx_in = idx_ff + CW'(1);
         skt_pkg::IDX_DEC:        idx_in = idx_ff - CW'(1);
         default:                 idx_in = idx_ff;
      endcase
   end

   assign count_in = (uw.cnt_inc && !hold) ? (count_ff + CW'(1)) : count_ff;

   // Result assembly
   always_comb begin
      rsp_in = '0;
      case (uw.rsp_op)
         skt_pkg::RSP_FULL:  rsp_in.status = skt_pkg::STATUS_FULL;
         skt_pkg::RSP_EMPTY: rsp_in.status = skt_pkg::STATUS_EMPTY;
         skt_pkg::RSP_SINGLE: begin
            rsp_in.frame_count = 2'd1;
            rsp_in.upper_id    = rd_entry.frame_id;
         end
         skt_pkg::RSP_BRACKET: begin
            rsp_in.frame_count = 2'd2;
            rsp_in.upper_id    = rd_entry.frame_id;
            rsp_in.lower_id    = prev_ff;
         end
         default: rsp_in.status = skt_pkg::STATUS_OK;
      endcase
   end

   // Drop the beat once taken, load a new one when a result step retires.
   always_comb begin
      if ((uw.rsp_op != skt_pkg::RSP_NONE) && !hold) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= skt_pkg::STEP_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (req_valid && !req_stall) begin
         req_ff <= req_beat;
      end
      if (uw.save_prev) begin
         prev_ff <= rd_entry.frame_id;
      end
      if ((uw.rsp_op != skt_pkg::RSP_NONE) && !hold) begin
         rsp_ff <= rsp_in;
      end
   end

   skt_ram #(
      .WIDTH ($bits(skt_pkg::entry_type)),
      .DEPTH (MAX_FRAMES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_entry)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   // Checks
   `SKT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_FRAMES),
                   "entry count beyond table size")
   `SKT_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && !req_stall,
                    pc_ff == skt_pkg::STEP_DISPATCH, "accepted beat not dispatched")
   `SKT_ASSERT_NEXT(a_count_only_on_place, clock, reset, pc_ff != skt_pkg::STEP_INS_PLACE,
                    count_ff == $past(count_ff), "entry count moved outside an insert")

endmodule
